/* rtl/core/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* rtl/core/tsp_pkg.sv */
package tsp_pkg;

  localparam int unsigned REQ_W  = 2;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned MS_W   = 16;
  localparam int unsigned FREQ_W = 16;
  localparam int unsigned LEN_IN_W = 8;
  localparam int unsigned STEP_OUT_W = 4;

  localparam logic [MS_W-1:0] MS_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_START = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_e;

  // one table entry as held in the step memory
  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0]   tone_ms;
    logic [MS_W-1:0]   pause_ms;
  } step_t;

endpackage

/* rtl/core/tsp_ram.sv */
module tsp_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/tone_sequence_player.sv */
// A request accepted in idle runs through the exec and out states; the result is
// shown for one cycle with done_o in the out state. A new request is taken only
// back in idle, and the step memory is read before and after the state update.
// reset: playback stopped, step 0, length 0; the step table is not cleared
module tone_sequence_player #(
  parameter int unsigned MAX_SEQ_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  step_slot_i,
  input  logic [15:0] step_freq_i,
  input  logic [15:0] step_tone_ms_i,
  input  logic [15:0] step_pause_ms_i,
  input  logic [7:0]  seq_length_i,
  output logic        done_o,
  output logic        tone_on_o,
  output logic [15:0] tone_freq_o,
  output logic        playing_o,
  output logic [3:0]  current_step_o,
  output logic        finished_o
);

  `include "assert_macros.svh"

  localparam int unsigned IDX_W = (MAX_SEQ_STEPS > 1) ? $clog2(MAX_SEQ_STEPS) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_SEQ_STEPS + 1);
  localparam int unsigned EXT_W = (IDX_W > tsp_pkg::SLOT_W) ? IDX_W : tsp_pkg::SLOT_W;
  localparam int unsigned ENTRY_W = $bits(tsp_pkg::step_t);

  tsp_pkg::state_e state_q, state_d;

  logic [tsp_pkg::REQ_W-1:0]    req_q;
  logic [tsp_pkg::LEN_IN_W-1:0] len_in_q;

  logic [LEN_W-1:0]        act_len_q, act_len_d;
  logic [IDX_W-1:0]        step_idx_q, step_idx_d;
  logic                    playing_q, playing_d;
  logic                    pause_q, pause_d;
  logic [tsp_pkg::MS_W-1:0] elapsed_q, elapsed_d;
  logic                    fin_q, fin_d;

  logic                    accept;
  logic                    ram_we;
  logic [EXT_W-1:0]        slot_ext;
  logic [EXT_W-1:0]        idx_ext;
  logic [IDX_W-1:0]        ram_raddr;
  tsp_pkg::step_t          ram_wdata;
  tsp_pkg::step_t          ram_rdata;
  logic [ENTRY_W-1:0]      ram_rdata_raw;
  logic [tsp_pkg::MS_W-1:0] elapsed_inc;
  logic [LEN_W:0]          idx_next;
  logic [LEN_W-1:0]        len_clamped;

  assign accept   = start && !busy;
  assign slot_ext = EXT_W'(step_slot_i);
  assign idx_ext  = EXT_W'(step_idx_q);

  // table writes go straight to memory in the accept cycle
  assign ram_we = accept && (req_type_i == tsp_pkg::REQ_WRITE) &&
                  (32'(step_slot_i) < MAX_SEQ_STEPS);
  assign ram_wdata = '{freq: step_freq_i, tone_ms: step_tone_ms_i,
                       pause_ms: step_pause_ms_i};

  // read current step on accept, the updated step during exec
  assign ram_raddr = (state_q == tsp_pkg::ST_EXEC) ? step_idx_d : step_idx_q;

  tsp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_SEQ_STEPS)
  ) u_step_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_ext[IDX_W-1:0]),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );

  assign ram_rdata = tsp_pkg::step_t'(ram_rdata_raw);

  assign elapsed_inc = (elapsed_q == tsp_pkg::MS_MAX) ? elapsed_q : elapsed_q + 1'b1;
  assign idx_next    = (LEN_W + 1)'(step_idx_q) + 1'b1;
  assign len_clamped = (32'(len_in_q) > MAX_SEQ_STEPS) ? LEN_W'(MAX_SEQ_STEPS)
                                                       : LEN_W'(len_in_q);

  always_comb begin
    state_d    = state_q;
    act_len_d  = act_len_q;
    step_idx_d = step_idx_q;
    playing_d  = playing_q;
    pause_d    = pause_q;
    elapsed_d  = elapsed_q;
    fin_d      = fin_q;
    case (state_q)
      tsp_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = tsp_pkg::ST_EXEC;
        end
      end
      tsp_pkg::ST_EXEC: begin
        state_d = tsp_pkg::ST_OUT;
        fin_d   = 1'b0;
        case (req_q)
          tsp_pkg::REQ_TICK: begin
            if (playing_q) begin
              elapsed_d = elapsed_inc;
              if (!pause_q) begin
                if (elapsed_inc >= ram_rdata.tone_ms) begin
                  pause_d   = 1'b1;
                  elapsed_d = '0;
                end
              end else if (elapsed_inc >= ram_rdata.pause_ms) begin
                if (idx_next >= (LEN_W + 1)'(act_len_q)) begin
                  // last step done
                  playing_d = 1'b0;
                  pause_d   = 1'b0;
                  elapsed_d = '0;
                  fin_d     = 1'b1;
                end else begin
                  step_idx_d = idx_next[IDX_W-1:0];
                  pause_d    = 1'b0;
                  elapsed_d  = '0;
                end
              end
            end
          end
          tsp_pkg::REQ_START: begin
            step_idx_d = '0;
            pause_d    = 1'b0;
            elapsed_d  = '0;
            if (len_clamped == '0) begin
              playing_d = 1'b0;
            end else begin
              act_len_d = len_clamped;
              playing_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      tsp_pkg::ST_OUT: begin
        state_d = tsp_pkg::ST_IDLE;
      end
      default: state_d = tsp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tsp_pkg::ST_IDLE;
      act_len_q  <= '0;
      step_idx_q <= '0;
      playing_q  <= 1'b0;
      pause_q    <= 1'b0;
      elapsed_q  <= '0;
      fin_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      act_len_q  <= act_len_d;
      step_idx_q <= step_idx_d;
      playing_q  <= playing_d;
      pause_q    <= pause_d;
      elapsed_q  <= elapsed_d;
      fin_q      <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= req_type_i;
      len_in_q <= seq_length_i;
    end
  end

  assign busy           = (state_q != tsp_pkg::ST_IDLE);
  assign done_o         = (state_q == tsp_pkg::ST_OUT);
  assign tone_on_o      = playing_q && !pause_q;
  assign tone_freq_o    = playing_q ? ram_rdata.freq : '0;
  assign playing_o      = playing_q;
  assign current_step_o = idx_ext[tsp_pkg::STEP_OUT_W-1:0];
  assign finished_o     = fin_q;

  `ASSERT_CLK(a_accept_busy, clk_i, rst_ni, accept |=> busy)
  `ASSERT_CLK(a_done_after_exec, clk_i, rst_ni,
              done_o |-> $past(state_q == tsp_pkg::ST_EXEC))
  `ASSERT_NEVER(a_finished_playing, clk_i, rst_ni, done_o && finished_o && playing_o)
  `ASSERT_CLK(a_idx_range, clk_i, rst_ni, 32'(step_idx_q) < MAX_SEQ_STEPS)

endmodule
